@@ sv/c8x_pkg.sv @@
// Shared types, codes and constants for the CHIP-8 instruction executor.
`timescale 1ns / 1ps
package c8x_pkg;
	localparam int RegCount   = 16;
	localparam int StackDepth = 16;
	localparam int FontBytes  = 5;
	localparam int SpW        = $clog2(StackDepth + 1);
	localparam int SiW        = $clog2(StackDepth);
	localparam int LpW        = $clog2(RegCount + 1);

	typedef enum logic [1:0] {
		CMD_EXEC  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_COLL  = 2'd2,
		CMD_OTHER = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		K_DONE  = 4'd0,
		K_WRITE = 4'd1,
		K_READ  = 4'd2,
		K_DRAW  = 4'd3,
		K_CLEAR = 4'd4,
		K_DELAY = 4'd5,
		K_SOUND = 4'd6,
		K_BAD   = 4'd7,
		K_OVF   = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		CFG_START = 2'd0,
		CFG_FONT  = 2'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMIT,
		ST_WAIT
	} state_t;

	// Datapath commands from the controller
	typedef struct packed {
		logic load;     // capture the request
		logic exec;     // execute the captured request, build first result
		logic next;     // build the next result of a multi-result request
	} ctl_cmd_t;

	// Datapath status to the controller
	typedef struct packed {
		logic more;     // another result follows the current one
	} dp_stat_t;
endpackage

@@ sv/chip8_instruction_execute.sv @@
// Top level of the CHIP-8 instruction executor.
// Usage:
//   Requests enter on the in_ channel (valid/ready) with cmd, instr, reply_data,
//   key_mask, delay_now and random_byte. cmd 0 executes an instruction, cmd 1
//   returns a byte for a pending register load, cmd 2 returns the draw collision
//   flag. Each request yields one or more results on the out_ channel
//   (valid/ready); last marks the final result of a request.
//   A request is captured when it is taken, executed in ST_EXEC, and its first
//   result is then presented in ST_EMIT. Each further result (BCD, register
//   dump, register load) is built when the previous one is taken.
//   The controller handles one request at a time.
//   A stalled receiver holds the current result stable and the block takes no
//   new request until the last result is taken.
//   Reset clears the registers, index, stack and pointers and loads the program
//   counter with 512; start_address and font_base return to 512 and 0.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
`timescale 1ns / 1ps
module chip8_instruction_execute import c8x_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] instr,
	input  logic [7:0]  reply_data,
	input  logic [15:0] key_mask,
	input  logic [7:0]  delay_now,
	input  logic [7:0]  random_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  kind,
	output logic [11:0] mem_address,
	output logic [7:0]  value,
	output logic [7:0]  draw_x,
	output logic [7:0]  draw_y,
	output logic [3:0]  draw_rows,
	output logic [11:0] next_pc,
	output logic        last
);
	ctl_cmd_t ctl;
	dp_stat_t st;

	c8x_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.cmd(ctl), .stat(st)
	);

	c8x_dp u_dp (
		.clk, .arst_n, .cmd(ctl), .stat(st),
		.cfg_we, .cfg_idx(cfg_index), .cfg_data,
		.in_cmd(cmd), .in_instr(instr), .in_reply(reply_data), .in_keys(key_mask),
		.in_delay(delay_now), .in_rand(random_byte),
		.kind, .mem_address, .value, .draw_x, .draw_y, .draw_rows, .next_pc, .last
	);

	// Never take a request while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	// A result with more to follow keeps the block busy
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid) else $error("lost result");
	// Last result returns to accepting requests
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready) else $error("stuck after last");
endmodule

@@ sv/c8x_ctrl.sv @@
// Controller state machine: sequences capture, execute and result hand-off.
`timescale 1ns / 1ps
module c8x_ctrl import c8x_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ctl_cmd_t cmd,
	input  dp_stat_t stat
);
	state_t state_q, state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.more) begin
						cmd.next = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

@@ sv/c8x_dp.sv @@
// Datapath: register file, index, program counter, call stack and result builder.
`timescale 1ns / 1ps
module c8x_dp import c8x_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    cmd,
	output dp_stat_t    stat,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [11:0] cfg_data,
	input  logic [1:0]  in_cmd,
	input  logic [15:0] in_instr,
	input  logic [7:0]  in_reply,
	input  logic [15:0] in_keys,
	input  logic [7:0]  in_delay,
	input  logic [7:0]  in_rand,
	output logic [3:0]  kind,
	output logic [11:0] mem_address,
	output logic [7:0]  value,
	output logic [7:0]  draw_x,
	output logic [7:0]  draw_y,
	output logic [3:0]  draw_rows,
	output logic [11:0] next_pc,
	output logic        last
);
	logic [7:0]     regs_q [RegCount];
	logic [11:0]    stack_q [StackDepth];
	logic [11:0]    index_q, pc_q, start_q, font_q;
	logic [SpW-1:0] sp_q;
	logic [LpW-1:0] lp_q;
	logic [1:0]     cmd_q;
	logic [15:0]    instr_q, keys_q;
	logic [7:0]     reply_q, delay_q, rand_q;
	// Multi-result sequencing (dump, load, BCD)
	logic [3:0]     cnt_q, cnt_end_q;
	logic [1:0]     mode_q;  // 1 dump, 2 load, 3 bcd
	logic [11:0]    base_q;
	logic [7:0]     bcd_v_q;

	logic [3:0]  x, y, n;
	logic [7:0]  nn, vx, vy;
	logic [11:0] nnn, pc2;
	logic [8:0]  sum;
	logic        pressed;
	logic [3:0]  first_key;
	logic [3:0]  t_dig, o_dig;
	logic [7:0]  tens;

	function automatic logic in_keys_bit(input logic [15:0] k, input logic [3:0] i);
		return k[i];
	endfunction

	assign x   = instr_q[11:8];
	assign y   = instr_q[7:4];
	assign n   = instr_q[3:0];
	assign nn  = instr_q[7:0];
	assign nnn = instr_q[11:0];
	assign vx  = regs_q[x];
	assign vy  = regs_q[y];
	assign pc2 = pc_q + 12'd2;
	assign sum = {1'b0, vx} + {1'b0, vy};
	assign pressed = (vx[7:4] == 4'd0) && in_keys_bit(keys_q, vx[3:0]);

	// Find the lowest pressed key
	always_comb begin
		first_key = 4'd0;
		for (int i = 15; i >= 0; i--) begin
			if (keys_q[i]) first_key = 4'(i);
		end
	end

	// Tens and ones digits: subtract hundreds, then multiply by 205 and shift
	always_comb begin
		tens = bcd_v_q;
		if (tens >= 8'd200) tens = tens - 8'd200;
		else if (tens >= 8'd100) tens = tens - 8'd100;
		t_dig = 4'(({8'd0, tens} * 16'd205) >> 11);
		o_dig = 4'(tens - ({4'd0, t_dig} * 8'd10));
	end

	assign stat.more = (mode_q != 2'd0) && (cnt_q != cnt_end_q);

	// Update state and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RegCount; i++) regs_q[i] <= 8'd0;
			for (int i = 0; i < StackDepth; i++) stack_q[i] <= 12'd0;
			index_q <= 12'd0;
			start_q <= 12'd512;
			font_q  <= 12'd0;
			pc_q    <= 12'd512;
			sp_q    <= '0;
			lp_q    <= '0;
			mode_q  <= 2'd0;
			cnt_q   <= 4'd0;
			cnt_end_q <= 4'd0;
			kind <= K_DONE; mem_address <= '0; value <= '0; draw_x <= '0;
			draw_y <= '0; draw_rows <= '0; next_pc <= '0; last <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_START) start_q <= cfg_data;
				else if (cfg_idx == CFG_FONT) font_q <= cfg_data;
			end
			if (cmd.load) begin
				cmd_q <= in_cmd; instr_q <= in_instr; reply_q <= in_reply;
				keys_q <= in_keys; delay_q <= in_delay; rand_q <= in_rand;
				bcd_v_q <= 8'd0;
			end
			if (cmd.exec) begin
				logic [11:0] npc;
				kind <= K_DONE; mem_address <= '0; value <= '0; draw_x <= '0;
				draw_y <= '0; draw_rows <= '0; last <= 1'b1;
				mode_q <= 2'd0;
				npc = pc_q;
				if (cmd_q == CMD_LOAD) begin
					if (lp_q < LpW'(RegCount)) begin
						regs_q[lp_q[3:0]] <= reply_q;
						lp_q <= lp_q + 1'b1;
					end
				end else if (cmd_q == CMD_COLL) begin
					regs_q[15] <= {7'd0, reply_q[0]};
				end else if (cmd_q == CMD_EXEC) begin
					npc = pc2;
					unique case (instr_q[15:12])
						4'h0: begin
							if (nnn == 12'h0E0) kind <= K_CLEAR;
							else if (nnn == 12'h0EE) begin
								logic [SpW-1:0] s;
								s = (sp_q != '0) ? sp_q - 1'b1 : sp_q;
								sp_q <= s;
								npc = (s < SpW'(StackDepth)) ? stack_q[s[SiW-1:0]] : stack_q[0];
							end else kind <= K_BAD;
						end
						4'h1: npc = nnn;
						4'h2: begin
							if (sp_q >= SpW'(StackDepth)) kind <= K_OVF;
							else begin
								stack_q[sp_q[SiW-1:0]] <= pc2;
								sp_q <= sp_q + 1'b1;
								npc = nnn;
							end
						end
						4'h3: if (vx == nn) npc = pc2 + 12'd2;
						4'h4: if (vx != nn) npc = pc2 + 12'd2;
						4'h5: if (vx == vy) npc = pc2 + 12'd2;
						4'h6: regs_q[x] <= nn;
						4'h7: regs_q[x] <= vx + nn;
						4'h8: begin
							unique case (n)
								4'h0: regs_q[x] <= vy;
								4'h1: regs_q[x] <= vx | vy;
								4'h2: regs_q[x] <= vx & vy;
								4'h3: regs_q[x] <= vx ^ vy;
								4'h4: begin regs_q[x] <= sum[7:0]; regs_q[15] <= {7'd0, sum[8]}; end
								4'h5: begin regs_q[x] <= vx - vy; regs_q[15] <= {7'd0, vx >= vy}; end
								4'h6: begin regs_q[x] <= vy >> 1; regs_q[15] <= {7'd0, vy[0]}; end
								4'h7: begin regs_q[x] <= vy - vx; regs_q[15] <= {7'd0, vy >= vx}; end
								4'hE: begin regs_q[x] <= vy << 1; regs_q[15] <= {7'd0, vy[7]}; end
								default: kind <= K_BAD;
							endcase
						end
						4'h9: if (vx != vy) npc = pc2 + 12'd2;
						4'hA: index_q <= nnn;
						4'hB: npc = nnn + {4'd0, regs_q[0]};
						4'hC: regs_q[x] <= rand_q & nn;
						4'hD: begin
							kind <= K_DRAW; mem_address <= index_q;
							draw_x <= vx; draw_y <= vy; draw_rows <= n;
						end
						4'hE: begin
							if (nn == 8'h9E) begin if (pressed) npc = pc2 + 12'd2; end
							else if (nn == 8'hA1) begin if (!pressed) npc = pc2 + 12'd2; end
							else kind <= K_BAD;
						end
						default: begin
							unique case (nn)
								8'h07: regs_q[x] <= delay_q;
								8'h0A: if (keys_q == 16'd0) npc = pc_q;
									else regs_q[x] <= {4'd0, first_key};
								8'h15: begin kind <= K_DELAY; value <= vx; end
								8'h18: begin kind <= K_SOUND; value <= vx; end
								8'h1E: index_q <= index_q + {4'd0, vx};
								8'h29: index_q <= font_q + 12'(FontBytes * vx[3:0]);
								8'h33: begin
									// Hundreds digit first, the rest after
									kind <= K_WRITE; mem_address <= index_q;
									value <= {6'd0, vx >= 8'd200, vx >= 8'd100 && vx < 8'd200};
									bcd_v_q <= vx; base_q <= index_q;
									mode_q <= 2'd3; cnt_q <= 4'd0; cnt_end_q <= 4'd2;
									last <= 1'b0;
								end
								8'h55, 8'h65: begin
									kind <= (nn == 8'h55) ? K_WRITE : K_READ;
									mem_address <= index_q;
									value <= (nn == 8'h55) ? regs_q[0] : 8'd0;
									base_q <= index_q;
									mode_q <= (nn == 8'h55) ? 2'd1 : 2'd2;
									cnt_q <= 4'd0; cnt_end_q <= x;
									last <= (x == 4'd0);
									index_q <= index_q + {8'd0, x} + 12'd1;
									if (nn == 8'h65) lp_q <= '0;
								end
								default: kind <= K_BAD;
							endcase
						end
					endcase
				end
				pc_q    <= npc;
				next_pc <= npc;
			end
			// Advance to the next result of a dump, load or BCD request
			if (cmd.next) begin
				logic [3:0] c;
				c = cnt_q + 4'd1;
				cnt_q <= c;
				mem_address <= base_q + {8'd0, c};
				last <= (c == cnt_end_q);
				unique case (mode_q)
					2'd1: value <= regs_q[c];
					2'd3: value <= {4'd0, (c == 4'd1) ? t_dig : o_dig};
					default: value <= 8'd0;
				endcase
			end
		end
	end
endmodule
